/* rtl/bwc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwc_pkg
// Types, register indexes and reset values shared by the watch controller.
// ----------------------------------------------------------------------------
package bwc_pkg;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ARM  = 2'd1,
    MODE_SHOW = 2'd2,
    MODE_SET  = 2'd3
  } mode_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_SECONDS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_SECONDS         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEP_MS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FLOOR_MS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADVANCES_PER_SPEEDUP = 3'd5;

  typedef struct packed {
    logic [5:0] display_seconds;
    logic [5:0] hold_seconds;
    logic [7:0] start_delay_ms;
    logic [7:0] delay_step_ms;
    logic [7:0] delay_floor_ms;
    logic [1:0] advances_per_speedup;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    display_seconds:      6'd10,
    hold_seconds:         6'd3,
    start_delay_ms:       8'd50,
    delay_step_ms:        8'd5,
    delay_floor_ms:       8'd5,
    advances_per_speedup: 2'd3
  };

  typedef struct packed {
    logic alarm;
    logic bwake;
    logic down;
    logic tick;
  } ev_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [3:0] hour;
    mode_t      mode;
    logic       press;
    logic [5:0] off_deadline;
    logic [5:0] hold_deadline;
    logic [7:0] advance_delay;
    logic [1:0] speedup_count;
    logic [7:0] wait_count;
    logic [3:0] led_hour;
    logic [5:0] led_min;
    logic       led_sec;
  } state_t;

  localparam state_t STATE_RESET = '{
    sec:           6'd0,
    min:           6'd12,
    hour:          4'd12,
    mode:          MODE_OFF,
    press:         1'b0,
    off_deadline:  6'd0,
    hold_deadline: 6'd0,
    advance_delay: 8'd0,
    speedup_count: 2'd0,
    wait_count:    8'd0,
    led_hour:      4'd0,
    led_min:       6'd0,
    led_sec:       1'b0
  };

  localparam logic [1:0] SPEEDUP_FIRST = 2'd2;

endpackage

/* rtl/bwc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwc_step
// Next-state logic for one event: clock count, display mode machine and
// set-mode minute advance with delay speed-up.
// ----------------------------------------------------------------------------
module bwc_step (
  input  bwc_pkg::cfg_t   cfg,
  input  bwc_pkg::ev_t    ev,
  input  bwc_pkg::state_t cur,
  output bwc_pkg::state_t nxt
);
  import bwc_pkg::*;

  function automatic logic [5:0] mod60_sum(input logic [5:0] a, input logic [5:0] b);
    logic [6:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s >= 7'd120) begin
        s = s - 7'd120;
      end else if (s >= 7'd60) begin
        s = s - 7'd60;
      end
      return s[5:0];
    end
  endfunction

  function automatic state_t bump_minute(input state_t st);
    state_t r;
    begin
      r = st;
      if (st.min >= 6'd59) begin
        r.min = 6'd0;
        if (st.hour >= 4'd12) begin
          r.hour = 4'd1;
        end else begin
          r.hour = st.hour + 4'd1;
        end
      end else begin
        r.min = st.min + 6'd1;
      end
      return r;
    end
  endfunction

  state_t     s;
  logic [7:0] w;
  logic [1:0] sc;
  logic       wake;

  always_comb begin
    s = cur;
    w = cur.wait_count;
    sc = cur.speedup_count;
    wake = ev.alarm | ev.bwake;

    if (ev.alarm) begin
      if (s.sec >= 6'd59) begin
        s.sec = 6'd0;
        s = bump_minute(s);
      end else begin
        s.sec = s.sec + 6'd1;
      end
    end

    if (cur.mode == MODE_SET) begin
      if (!ev.down) begin
        s.mode = MODE_ARM;
      end else begin
        if (ev.tick && w != 8'd0) begin
          w = w - 8'd1;
        end
        if (w == 8'd0) begin
          s.sec = 6'd0;
          s = bump_minute(s);
          if (sc != 2'd0) begin
            sc = sc - 2'd1;
          end
          if (sc == 2'd0 && s.advance_delay > cfg.delay_floor_ms) begin
            sc = cfg.advances_per_speedup;
            if (s.advance_delay > cfg.delay_step_ms) begin
              s.advance_delay = s.advance_delay - cfg.delay_step_ms;
            end else begin
              s.advance_delay = 8'd0;
            end
          end
          s.speedup_count = sc;
          s.led_hour = s.hour;
          s.led_min = s.min;
          s.led_sec = 1'b0;
          s.wait_count = s.advance_delay;
        end else begin
          s.wait_count = w;
        end
      end
    end else if (wake) begin
      case (cur.mode)
        MODE_OFF: begin
          s.led_hour = 4'd0;
          s.led_min = 6'd0;
          s.led_sec = 1'b0;
          if (ev.bwake) begin
            s.mode = MODE_ARM;
            s.press = 1'b1;
            s.led_hour = s.hour;
            s.led_min = s.min;
            s.led_sec = 1'b1;
          end else begin
            s.press = 1'b0;
          end
        end
        MODE_ARM: begin
          s.led_hour = s.hour;
          s.led_min = s.min;
          s.led_sec = ~cur.led_sec;
          s.off_deadline = mod60_sum(s.sec, cfg.display_seconds);
          s.hold_deadline = mod60_sum(s.sec, cfg.hold_seconds);
          s.mode = MODE_SHOW;
        end
        default: begin
          s.led_hour = s.hour;
          s.led_min = s.min;
          s.led_sec = ~cur.led_sec;
          if (cur.off_deadline == s.sec) begin
            s.mode = MODE_OFF;
          end else if (ev.down && !cur.press) begin
            s.mode = MODE_ARM;
            s.press = 1'b1;
          end else if (cur.hold_deadline == s.sec && ev.down && cur.press) begin
            s.mode = MODE_SET;
            s.advance_delay = cfg.start_delay_ms;
            s.speedup_count = SPEEDUP_FIRST;
            s.wait_count = 8'd0;
          end else if (!ev.down && cur.press) begin
            s.press = 1'b0;
          end
        end
      endcase
    end

    nxt = s;
  end

endmodule

/* rtl/binary_watch_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_watch_controller
// Binary LED watch: 12-hour time keeping and four-mode display control.
// ----------------------------------------------------------------------------
// Each input transaction is one event (second alarm, button wake, button
// level, millisecond tick). Every input transaction yields exactly one output
// transaction carrying the latched LED pattern and the display mode.
// An event taken into the input register is held there, processed by the
// step logic into the state and result registers when it advances, and the
// result is presented from then on; one transaction per cycle is sustained
// while out_stall is low, as the whole update fits between those registers.
// When out_stall is high with a result pending, the result register holds;
// if the input register also holds an event, it keeps it and in_stall rises
// in the same cycle; nothing is dropped. Configuration writes take effect at
// the next edge; the user makes them only while no transaction is in flight;
// the block does not enforce this. A synchronous reset empties both registers
// and loads 12:12:00, off mode, dark LED state, default register values.
// ----------------------------------------------------------------------------
module binary_watch_controller (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bwc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            second_alarm,
  input  logic                            button_wake,
  input  logic                            button_down,
  input  logic                            ms_tick,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [3:0]                      hour_leds,
  output logic [5:0]                      minute_leds,
  output logic                            second_led,
  output logic [1:0]                      display_mode
);
  import bwc_pkg::*;

  cfg_t   cfg;
  ev_t    s1_ev;
  logic   s1_valid;
  logic   s1_adv;
  state_t st;
  state_t st_next;

  assign s1_adv = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISPLAY_SECONDS:      cfg.display_seconds <= cfg_data[5:0];
        REG_HOLD_SECONDS:         cfg.hold_seconds <= cfg_data[5:0];
        REG_START_DELAY_MS:       cfg.start_delay_ms <= cfg_data;
        REG_DELAY_STEP_MS:        cfg.delay_step_ms <= cfg_data;
        REG_DELAY_FLOOR_MS:       cfg.delay_floor_ms <= cfg_data;
        REG_ADVANCES_PER_SPEEDUP: cfg.advances_per_speedup <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_ev <= '{alarm: second_alarm, bwake: button_wake, down: button_down,
                 tick: ms_tick};
    end
  end

  bwc_step u_step (
    .cfg (cfg),
    .ev  (s1_ev),
    .cur (st),
    .nxt (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hour_leds    <= st_next.led_hour;
      minute_leds  <= st_next.led_min;
      second_led   <= st_next.led_sec;
      display_mode <= st_next.mode;
    end
  end

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    st.sec < 6'd60 && st.min < 6'd60 && st.hour >= 4'd1 && st.hour <= 4'd12)
    else $error("time count out of range");

  a_deadline_range: assert property (@(posedge clk) disable iff (rst)
    st.off_deadline < 6'd60 && st.hold_deadline < 6'd60)
    else $error("deadline out of range");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid && display_mode == $past(st_next.mode))
    else $error("processed event did not produce a result");

  a_stall_holds_event: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid && $stable(s1_ev))
    else $error("held event lost while stalled");

endmodule

/* dv/tb_binary_watch_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_watch_controller
// Self-checking bench for the binary watch controller. A scoreboard keeps its
// own copy of the time, the display machine and the registers, predicts the
// LED pattern and mode for every accepted event and compares each output
// transaction against it. Stimulus is a directed opening, then mode-aware
// press, hold, set and release episodes mixed with noise, under six register
// settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_binary_watch_controller;
  import bwc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int LIVE_PER_PHASE = 210;

  localparam logic [3:0] OPENING [17] = '{
    4'b0000, 4'b0001, 4'b1000, 4'b0110, 4'b1010, 4'b1010, 4'b1011, 4'b1010,
    4'b0010, 4'b0011, 4'b1011, 4'b0000, 4'b0100, 4'b0010, 4'b1000, 4'b1010,
    4'b1111
  };

  typedef struct packed {
    logic [3:0] hour;
    logic [5:0] minute;
    logic       sec_led;
    mode_t      mode;
  } display_t;

  class watch_scoreboard;
    cfg_t     cfg;
    state_t   st;
    display_t expected_displays[$];
    int       errors;
    int       checked;
    int       set_results;

    function new();
      cfg = CFG_RESET;
      st = STATE_RESET;
      errors = 0;
      checked = 0;
      set_results = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DISPLAY_SECONDS:      cfg.display_seconds = val[5:0];
        REG_HOLD_SECONDS:         cfg.hold_seconds = val[5:0];
        REG_START_DELAY_MS:       cfg.start_delay_ms = val;
        REG_DELAY_STEP_MS:        cfg.delay_step_ms = val;
        REG_DELAY_FLOOR_MS:       cfg.delay_floor_ms = val;
        REG_ADVANCES_PER_SPEEDUP: cfg.advances_per_speedup = val[1:0];
        default: ;
      endcase
    endfunction

    function void next_minute();
      if (st.min >= 6'd59) begin
        st.min = '0;
        st.hour = (st.hour >= 4'd12) ? 4'd1 : st.hour + 4'd1;
      end else begin
        st.min = st.min + 6'd1;
      end
    endfunction

    function void light_time();
      st.led_hour = st.hour;
      st.led_min = st.min;
    endfunction

    function logic [5:0] wrap60(logic [5:0] a, logic [5:0] b);
      int s;
      s = (int'(a) + int'(b)) % 60;
      return s[5:0];
    endfunction

    function void set_advance();
      st.sec = '0;
      next_minute();
      if (st.speedup_count != 2'd0) st.speedup_count = st.speedup_count - 2'd1;
      if (st.speedup_count == 2'd0 && st.advance_delay > cfg.delay_floor_ms) begin
        st.speedup_count = cfg.advances_per_speedup;
        st.advance_delay = (st.advance_delay > cfg.delay_step_ms) ?
                           st.advance_delay - cfg.delay_step_ms : 8'd0;
      end
      light_time();
      st.led_sec = 1'b0;
    endfunction

    function void note_event(ev_t ev);
      logic wake;
      wake = ev.alarm | ev.bwake;
      if (ev.alarm) begin
        if (st.sec >= 6'd59) begin
          st.sec = '0;
          next_minute();
        end else begin
          st.sec = st.sec + 6'd1;
        end
      end
      if (st.mode == MODE_SET) begin
        if (!ev.down) begin
          st.mode = MODE_ARM;
        end else begin
          if (ev.tick && st.wait_count != 8'd0) st.wait_count = st.wait_count - 8'd1;
          if (st.wait_count == 8'd0) begin
            set_advance();
            st.wait_count = st.advance_delay;
          end
        end
      end else if (wake) begin
        case (st.mode)
          MODE_OFF: begin
            st.led_hour = '0;
            st.led_min = '0;
            st.led_sec = 1'b0;
            if (ev.bwake) begin
              st.mode = MODE_ARM;
              st.press = 1'b1;
              light_time();
              st.led_sec = 1'b1;
            end else begin
              st.press = 1'b0;
            end
          end
          MODE_ARM: begin
            light_time();
            st.led_sec = ~st.led_sec;
            st.off_deadline = wrap60(st.sec, cfg.display_seconds);
            st.hold_deadline = wrap60(st.sec, cfg.hold_seconds);
            st.mode = MODE_SHOW;
          end
          default: begin
            light_time();
            st.led_sec = ~st.led_sec;
            if (st.off_deadline == st.sec) begin
              st.mode = MODE_OFF;
            end else if (ev.down && !st.press) begin
              st.mode = MODE_ARM;
              st.press = 1'b1;
            end else if (st.hold_deadline == st.sec && ev.down && st.press) begin
              st.mode = MODE_SET;
              st.advance_delay = cfg.start_delay_ms;
              st.speedup_count = SPEEDUP_FIRST;
              st.wait_count = '0;
            end else if (!ev.down && st.press) begin
              st.press = 1'b0;
            end
          end
        endcase
      end
      expected_displays.push_back('{hour: st.led_hour, minute: st.led_min,
                                    sec_led: st.led_sec, mode: st.mode});
    endfunction

    task check_display(display_t got);
      display_t want;
      if (expected_displays.size() == 0) begin
        report("output transaction with nothing expected");
        return;
      end
      want = expected_displays.pop_front();
      checked++;
      if (got.mode == MODE_SET) set_results++;
      if (got.hour != want.hour)
        report($sformatf("hour_leds got %0d expected %0d", got.hour, want.hour));
      if (got.minute != want.minute)
        report($sformatf("minute_leds got %0d expected %0d", got.minute, want.minute));
      if (got.sec_led != want.sec_led)
        report($sformatf("second_led got %0b expected %0b", got.sec_led, want.sec_led));
      if (got.mode != want.mode)
        report($sformatf("display_mode got %s expected %s", got.mode.name(), want.mode.name()));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  second_alarm = 1'b0;
  logic                  button_wake = 1'b0;
  logic                  button_down = 1'b0;
  logic                  ms_tick = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [3:0]            hour_leds;
  logic [5:0]            minute_leds;
  logic                  second_led;
  logic [1:0]            display_mode;

  watch_scoreboard sb;
  logic            calm = 1'b0;
  int              n_live = 0;
  int              n_sent = 0;

  binary_watch_controller DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .second_alarm (second_alarm),
    .button_wake  (button_wake),
    .button_down  (button_down),
    .ms_tick      (ms_tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hour_leds    (hour_leds),
    .minute_leds  (minute_leds),
    .second_led   (second_led),
    .display_mode (display_mode)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int draw_wait();
    if (calm) return 0;
    return int'($urandom_range(0, 16));
  endfunction

  function automatic logic coin();
    return $urandom_range(0, 1) == 1;
  endfunction

  function automatic ev_t make_event(logic alarm, logic bwake, logic down, logic tick);
    ev_t e;
    e.alarm = alarm;
    e.bwake = bwake;
    e.down = down;
    e.tick = tick;
    return e;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_registers(input logic [7:0] ds, input logic [7:0] hs,
                               input logic [7:0] sd, input logic [7:0] ds_step,
                               input logic [7:0] fl, input logic [7:0] ap);
    write_reg(REG_DISPLAY_SECONDS, ds);
    write_reg(REG_HOLD_SECONDS, hs);
    write_reg(REG_START_DELAY_MS, sd);
    write_reg(REG_DELAY_STEP_MS, ds_step);
    write_reg(REG_DELAY_FLOOR_MS, fl);
    write_reg(REG_ADVANCES_PER_SPEEDUP, ap);
  endtask

  task automatic send_event(input ev_t ev);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    second_alarm <= ev.alarm;
    button_wake <= ev.bwake;
    button_down <= ev.down;
    ms_tick <= ev.tick;
    if (ev.alarm || ev.bwake || sb.st.mode == MODE_SET) n_live++;
    n_sent++;
    do @(posedge clk); while (in_stall);
    sb.note_event(ev);
    @(negedge clk);
  endtask

  // drop valid, let every result arrive, then allow the pipeline to settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_displays.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_episode();
    int kind;
    int n;
    calm = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      send_event(make_event(coin(), 1'b1, 1'b1, coin()));
      n = 0;
      while (sb.st.mode != MODE_SET && sb.st.mode != MODE_OFF && n < 70) begin
        send_event(make_event(1'b1, $urandom_range(0, 7) == 0,
                              $urandom_range(0, 24) != 0, coin()));
        n++;
      end
      if (sb.st.mode == MODE_SET) begin
        repeat ($urandom_range(1, 150))
          send_event(make_event($urandom_range(0, 7) == 0, coin(),
                                $urandom_range(0, 99) != 0, $urandom_range(0, 3) != 0));
      end
      send_event(make_event(coin(), coin(), 1'b0, coin()));
    end else if (kind <= 7) begin
      send_event(make_event(coin(), 1'b1, 1'b1, coin()));
      repeat ($urandom_range(1, 6)) send_event(make_event(1'b1, coin(), coin(), coin()));
    end else begin
      repeat ($urandom_range(1, 12)) send_event(ev_t'(4'($urandom_range(0, 15))));
    end
    n = 0;
    while (sb.st.mode != MODE_OFF && n < 80) begin
      send_event(make_event(1'b1, $urandom_range(0, 9) == 0,
                            $urandom_range(0, 3) == 0, coin()));
      n++;
    end
  endtask

  task automatic run_phase();
    n_live = 0;
    while (n_live < LIVE_PER_PHASE) run_episode();
    calm = 1'b0;
    drain();
  endtask

  initial begin
    display_t got;
    @(negedge clk);
    forever begin
      int k;
      k = draw_wait();
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.hour = hour_leds;
      got.minute = minute_leds;
      got.sec_led = second_led;
      got.mode = mode_t'(display_mode);
      sb.check_display(got);
      @(negedge clk);
    end
  end

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (OPENING[i]) send_event(ev_t'(OPENING[i]));
    repeat (11) send_event(make_event(1'b1, 1'b0, 1'b0, 1'b0));
    drain();

    run_phase();
    set_registers(8'd59, 8'd1, 8'd255, 8'd255, 8'd0, 8'd0);
    run_phase();
    set_registers(8'hFF, 8'hC2, 8'd0, 8'd0, 8'd255, 8'd1);
    write_reg(REG_UNUSED_LO, 8'hA5);
    run_phase();
    set_registers(8'd30, 8'h45, 8'd20, 8'd3, 8'd2, 8'd2);
    write_reg(REG_UNUSED_HI, 8'h5A);
    run_phase();
    set_registers(8'h80, 8'hC0, 8'd200, 8'd7, 8'd100, 8'd2);
    run_phase();
    set_registers(8'd12, 8'd2, 8'd1, 8'd1, 8'd0, 8'hFF);
    run_phase();

    if (sb.expected_displays.size() != 0) sb.report("results still outstanding at end");
    $display("Sent %0d events under six register settings; checked %0d results.",
             n_sent, sb.checked);
    $display("%0d results were taken in set mode; %0d mismatches.",
             sb.set_results, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: run did not complete.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
